// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the apogee detector.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- rtl/core/adwm_pkg.sv -----
// Constants and types for the apogee detector with moving window.
// No dependencies.
package adwm_pkg;

    localparam int SUM_BITS      = 30;
    localparam int COUNT_BITS    = 7;
    localparam int THRESH_BITS   = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [THRESH_BITS-1:0]   t_thresh;

    // Configuration register indexes
    localparam t_cfg_idx CFG_WINDOW_LENGTH      = 1'b0;
    localparam t_cfg_idx CFG_DECREASE_THRESHOLD = 1'b1;

    localparam int      WINDOW_LENGTH_RESET = 64;
    localparam t_thresh THRESHOLD_RESET     = 8'd5;
    localparam t_thresh RUN_MAX             = 8'hFF;

endpackage

// ----- rtl/core/apogee_detect_with_moving_window_unit.sv -----
// Apogee detector with a moving-window sum over a ring memory.
// Depends on adwm_pkg and assert_macros.svh.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+---------------------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_altitude
//  out      | output    | o_out_valid / i_out_ready  | o_window_sum, o_oldest_sample,
//           |           |                            | o_sample_count, o_apogee_reached,
//           |           |                            | o_reference_altitude
//  cfg      | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One sample is taken per cycle while o_in_ready is high; its result goes to r_out or r_skid.
// The rate is set by the ring memory: one write and one prefetch read per cycle, with the
// oldest and next-oldest entries held in registers so the sum update never waits on a read.
// Reset is synchronous, active low; the ring itself needs no clearing after reset.
// A two-entry output buffer lets one transfer in while a result waits; with both entries
// full, o_in_ready drops until the consumer takes a result.
`include "assert_macros.svh"

module apogee_detect_with_moving_window_unit #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  adwm_pkg::t_cfg_idx               i_cfg_idx,
    input  adwm_pkg::t_cfg_data              i_cfg_data,
    // sample channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_altitude,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [adwm_pkg::SUM_BITS-1:0] o_window_sum,
    output logic signed [SAMPLE_BITS-1:0]    o_oldest_sample,
    output adwm_pkg::t_count                 o_sample_count,
    output logic                             o_apogee_reached,
    output logic signed [SAMPLE_BITS-1:0]    o_reference_altitude
);
    import adwm_pkg::*;

    localparam int AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int PW       = (AW > COUNT_BITS) ? AW : COUNT_BITS;
    localparam int EXT_BITS = SAMPLE_BITS + SUM_BITS;
    localparam int LEN_RST  = (WINDOW_DEPTH < WINDOW_LENGTH_RESET) ? WINDOW_DEPTH
                                                                   : WINDOW_LENGTH_RESET;

    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [SAMPLE_BITS-1:0] oldest;
        t_count                 count;
        logic                   flag;
        logic [SAMPLE_BITS-1:0] ref_alt;
    } t_result;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_ring [WINDOW_DEPTH];  // sample ring
    logic [SAMPLE_BITS-1:0] r_rd_data;              // registered ring read

    t_count                 r_len;        // effective window length, 1..WINDOW_DEPTH
    t_thresh                r_thresh;
    logic [PW-1:0]          r_oldest;
    t_count                 r_fill;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_head;       // copy of ring[oldest]
    logic [SAMPLE_BITS-1:0] r_next;       // copy of ring[oldest + 1]
    logic                   r_next_pend;  // ring[oldest + 1] is arriving from the read port
    logic [SAMPLE_BITS-1:0] r_prev;
    t_thresh                r_run;
    logic                   r_flag;

    logic                   r_out_valid;
    logic                   r_skid_valid;
    t_result                r_out;
    t_result                r_skid;

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic                   w_full;
    logic                   w_len_one;
    logic                   w_len_two;
    logic                   w_read_next;
    logic [SAMPLE_BITS-1:0] w_next;
    logic [PW:0]            w_len_x;
    logic [PW:0]            w_inc1;
    logic [PW:0]            w_inc2;
    logic [PW:0]            w_fill_pos;
    logic [PW:0]            w_slot;
    logic [PW:0]            w_rd_pos;
    logic [EXT_BITS-1:0]    w_smp_ext;
    logic [EXT_BITS-1:0]    w_head_ext;
    logic [SUM_BITS-1:0]    w_drop;
    logic                   w_falling;
    t_count                 w_cfg_len;
    t_count                 w_eff_len;

    logic [PW-1:0]          n_oldest;
    t_count                 n_fill;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SAMPLE_BITS-1:0] n_head;
    logic [SAMPLE_BITS-1:0] n_next;
    logic [SAMPLE_BITS-1:0] n_prev;
    t_thresh                n_run;
    logic                   n_flag;
    t_result                w_result;

    assign o_in_ready = !r_skid_valid;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_out_valid && i_out_ready;

    assign w_full    = (r_fill == r_len);
    assign w_len_one = (r_len == COUNT_BITS'(1));
    assign w_len_two = (r_len == COUNT_BITS'(2));
    // prefetch the entry after the new oldest one when the window slides and is longer than two
    assign w_read_next = w_full && !w_len_one && !w_len_two;

    // take the prefetched entry straight off the read port in the cycle it lands
    assign w_next = r_next_pend ? r_rd_data : r_next;

    // ring position arithmetic: every sum in use stays below twice the length,
    // so one compare and subtract wraps it
    always_comb begin
        w_len_x    = (PW+1)'(r_len);
        w_inc1     = {1'b0, r_oldest} + (PW+1)'(1);
        if (w_inc1 >= w_len_x) w_inc1 = w_inc1 - w_len_x;
        w_inc2     = {1'b0, r_oldest} + (PW+1)'(2);
        if (w_inc2 >= w_len_x) w_inc2 = w_inc2 - w_len_x;
        w_fill_pos = {1'b0, r_oldest} + (PW+1)'(r_fill);
        if (w_fill_pos >= w_len_x) w_fill_pos = w_fill_pos - w_len_x;
        w_slot     = w_full ? {1'b0, r_oldest} : w_fill_pos;
        w_rd_pos   = w_inc2;
    end

    // window sum: drop the oldest sample when full, add the new one
    assign w_smp_ext  = {{SUM_BITS{i_altitude[SAMPLE_BITS-1]}}, i_altitude};
    assign w_head_ext = {{SUM_BITS{r_head[SAMPLE_BITS-1]}}, r_head};
    assign w_drop     = w_full ? w_head_ext[SUM_BITS-1:0] : '0;
    assign n_sum      = r_sum - w_drop + w_smp_ext[SUM_BITS-1:0];

    always_comb begin
        n_oldest = r_oldest;
        n_fill   = r_fill;
        n_head   = r_head;
        n_next   = w_next;
        if (w_full) begin
            n_oldest = w_inc1[PW-1:0];
            if (w_len_one) begin
                n_head = i_altitude;
            end else begin
                n_head = w_next;
                if (w_len_two) n_next = i_altitude;
            end
        end else begin
            n_fill = r_fill + COUNT_BITS'(1);
            if (r_fill == '0) n_head = i_altitude;
            if (r_fill == COUNT_BITS'(1)) n_next = i_altitude;
        end
    end

    // decrease detector: frozen once apogee is flagged
    assign w_falling = !r_prev[SAMPLE_BITS-1] && ($signed(i_altitude) < $signed(r_prev));

    always_comb begin
        n_prev = r_prev;
        n_run  = r_run;
        n_flag = r_flag;
        if (!r_flag) begin
            if (w_falling) n_run = (r_run == RUN_MAX) ? RUN_MAX : r_run + THRESH_BITS'(1);
            else           n_run = '0;
            n_flag = (n_run >= r_thresh);
            n_prev = i_altitude;
        end
    end

    assign w_result.sum     = n_sum;
    assign w_result.oldest  = n_head;
    assign w_result.count   = w_full ? r_fill : n_fill;
    assign w_result.flag    = n_flag;
    assign w_result.ref_alt = n_prev;

    // clamp a written window length into 1..WINDOW_DEPTH
    assign w_cfg_len = i_cfg_data[COUNT_BITS-1:0];
    always_comb begin
        if (w_cfg_len == '0)                 w_eff_len = COUNT_BITS'(1);
        else if (int'(w_cfg_len) > WINDOW_DEPTH) w_eff_len = COUNT_BITS'(WINDOW_DEPTH);
        else                                 w_eff_len = w_cfg_len;
    end

    // ------------------------------------------------------------------
    // Ring memory: one write, one read, read data registered
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ring[w_slot[AW-1:0]] <= i_altitude;
        end
        if (w_in_xfer && w_read_next) begin
            r_rd_data <= r_ring[w_rd_pos[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Control and window state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= COUNT_BITS'(LEN_RST);
            r_thresh    <= THRESHOLD_RESET;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_next_pend <= 1'b0;
            r_prev      <= '1;
            r_run       <= '0;
            r_flag      <= 1'b0;
        end else begin
            r_next_pend <= w_in_xfer && w_read_next;
            if (w_in_xfer) begin
                r_oldest <= n_oldest;
                r_fill   <= n_fill;
                r_sum    <= n_sum;
                r_prev   <= n_prev;
                r_run    <= n_run;
                r_flag   <= n_flag;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: begin
                        // a new capacity empties the window; the detector keeps going
                        r_len    <= w_eff_len;
                        r_oldest <= '0;
                        r_fill   <= '0;
                        r_sum    <= '0;
                    end
                    CFG_DECREASE_THRESHOLD: begin
                        r_thresh <= i_cfg_data[THRESH_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // hold the copies of the two oldest entries; capture prefetched data when idle
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_head <= n_head;
            r_next <= n_next;
        end else begin
            r_next <= w_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_xfer;
            end
        end else if (w_in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_xfer) begin
            if (r_skid_valid) r_out <= r_skid;
            else if (w_in_xfer) r_out <= w_result;
        end else if (w_in_xfer) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_window_sum         = r_out.sum;
    assign o_oldest_sample      = r_out.oldest;
    assign o_sample_count       = r_out.count;
    assign o_apogee_reached     = r_out.flag;
    assign o_reference_altitude = r_out.ref_alt;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > r_len, "fill count exceeds window length")
    `ASSERT_NEVER(a_oldest_bound, i_clk, i_rst_n, r_oldest >= PW'(r_len), "oldest position out of window")
    `ASSERT_PROP(a_flag_sticky, i_clk, i_rst_n, r_flag |=> r_flag, "apogee flag cleared")
    `ASSERT_PROP(a_skid_order, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid entry ahead of output")
    `ASSERT_PROP(a_prefetch_src, i_clk, i_rst_n, r_next_pend |-> $past(w_in_xfer), "prefetch without a transfer")

endmodule

// ----- verif/tb_apogee_detect_with_moving_window_unit.sv -----
// Self-checking testbench for the apogee detector with moving window.
// Depends on adwm_pkg and the RTL of apogee_detect_with_moving_window_unit.
// A class predicts each result from the accepted samples; tasks drive in and cfg.
module tb_apogee_detect_with_moving_window_unit;
    import adwm_pkg::*;

    localparam int     SAMPLE_W    = 24;
    localparam int     DEPTH       = 64;
    localparam longint ALT_MAX     = 64'sd8388607;
    localparam longint ALT_MIN     = -64'sd8388608;
    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     RANDOM_ITEMS = 1450;

    // Shapes of random stimulus per phase
    typedef enum int {
        PH_FLIGHT,
        PH_GROUND,
        PH_NOISE,
        PH_EXTREME,
        PH_SATURATE
    } t_phase_kind;

    typedef struct {
        logic signed [SUM_BITS-1:0] sum;
        logic signed [SAMPLE_W-1:0] oldest;
        t_count                     count;
        logic                       apogee;
        logic signed [SAMPLE_W-1:0] ref_alt;
    } t_window_result;

    // Predicts the window and detector state from accepted transfers and
    // holds the results still owed by the block, oldest first.
    class apogee_checker;
        logic signed [SAMPLE_W-1:0] ring [DEPTH];
        int                         head;
        int                         fill;
        logic signed [SUM_BITS-1:0] sum;
        logic signed [SAMPLE_W-1:0] prev;
        t_thresh                    run;
        logic                       flag;
        t_count                     wlen;
        t_thresh                    thresh;
        t_window_result             results [$];
        int                         errors;

        function new();
            head   = 0;
            fill   = 0;
            sum    = '0;
            prev   = '1;
            run    = '0;
            flag   = 1'b0;
            wlen   = t_count'(WINDOW_LENGTH_RESET);
            thresh = THRESHOLD_RESET;
            errors = 0;
        endfunction

        function void note_config(t_cfg_idx idx, t_cfg_data data);
            if (idx == CFG_WINDOW_LENGTH) begin
                // a new capacity empties the window, detector state stays
                wlen = data[COUNT_BITS-1:0];
                head = 0;
                fill = 0;
                sum  = '0;
            end else begin
                thresh = data;
            end
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] alt);
            t_window_result want;
            int             len;
            len = (wlen == 0) ? 1 : ((int'(wlen) > DEPTH) ? DEPTH : int'(wlen));
            if (head >= len) head = 0;
            if (fill > len) fill = len;
            if (fill >= len) begin
                sum  = sum - ring[head];
                head = (head + 1) % len;
                fill--;
            end
            ring[(head + fill) % len] = alt;
            sum = sum + alt;
            fill++;
            if (!flag) begin
                if (prev >= 0 && alt < prev) begin
                    if (run != RUN_MAX) run++;
                end else begin
                    run = '0;
                end
                if (run >= thresh) flag = 1'b1;
                prev = alt;
            end
            want.sum     = sum;
            want.oldest  = ring[head];
            want.count   = t_count'(fill);
            want.apogee  = flag;
            want.ref_alt = prev;
            results.push_back(want);
        endfunction

        function void match_result(t_window_result got);
            t_window_result want;
            if (results.size() == 0) begin
                $error("result with nothing outstanding: window_sum %0d", got.sum);
                errors++;
                return;
            end
            want = results.pop_front();
            if (got.sum !== want.sum) begin
                $error("window_sum: expected %0d, got %0d", want.sum, got.sum);
                errors++;
            end
            if (got.oldest !== want.oldest) begin
                $error("oldest_sample: expected %0d, got %0d", want.oldest, got.oldest);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("sample_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.apogee !== want.apogee) begin
                $error("apogee_reached: expected %0b, got %0b", want.apogee, got.apogee);
                errors++;
            end
            if (got.ref_alt !== want.ref_alt) begin
                $error("reference_altitude: expected %0d, got %0d", want.ref_alt, got.ref_alt);
                errors++;
            end
        endfunction

        function int pending();
            return results.size();
        endfunction
    endclass

    // Every input holds a known value from time zero
    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_cfg_we   = 1'b0;
    t_cfg_idx                    i_cfg_idx  = CFG_WINDOW_LENGTH;
    t_cfg_data                   i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0]  i_altitude = '0;
    logic                        i_out_ready = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [SUM_BITS-1:0]  o_window_sum;
    logic signed [SAMPLE_W-1:0]  o_oldest_sample;
    t_count                      o_sample_count;
    logic                        o_apogee_reached;
    logic signed [SAMPLE_W-1:0]  o_reference_altitude;

    apogee_checker chk;
    int            sent         = 0;
    int            cycle_count  = 0;
    int            ready_gap    = 0;
    int            hold_left    = 0;
    bit            hold_done    = 1'b0;
    logic          hold_req     = 1'b0;
    bit            calm         = 1'b0;
    bit            allow_apogee = 1'b0;

    apogee_detect_with_moving_window_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_altitude           (i_altitude),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_window_sum         (o_window_sum),
        .o_oldest_sample      (o_oldest_sample),
        .o_sample_count       (o_sample_count),
        .o_apogee_reached     (o_apogee_reached),
        .o_reference_altitude (o_reference_altitude)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_apogee_detect_with_moving_window_unit: errors");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    // Calm phases run flat out on both sides.
    function automatic int idle_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_sample(longint v);
        if (v > ALT_MAX) return ALT_MAX[SAMPLE_W-1:0];
        if (v < ALT_MIN) return ALT_MIN[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

    // The apogee flag is sticky and reset comes only once, so keep it clear
    // until the closing flight: turn a fall that would complete the run into
    // a level sample, which clears the run instead.
    function automatic logic signed [SAMPLE_W-1:0] hold_off_apogee(
        logic signed [SAMPLE_W-1:0] alt
    );
        if (allow_apogee || chk.flag) return alt;
        if (chk.prev >= 0 && alt < chk.prev && int'(chk.run) + 1 >= int'(chk.thresh))
            return chk.prev;
        return alt;
    endfunction

    // Result side: check each transfer, then idle the ready at random.
    // The one long hold-off lets the output buffer fill and stall the input.
    always @(posedge i_clk) begin
        t_window_result seen;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen.sum     = o_window_sum;
                seen.oldest  = o_oldest_sample;
                seen.count   = o_sample_count;
                seen.apogee  = o_apogee_reached;
                seen.ref_alt = o_reference_altitude;
                chk.match_result(seen);
                ready_gap = idle_gap();
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = $urandom_range(200, 300);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one sample and hold it until the transfer. Valid stays high into
    // the next call, so back-to-back samples never drop it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] alt);
        int                         gap;
        logic signed [SAMPLE_W-1:0] val;
        gap = idle_gap();
        val = hold_off_apogee(alt);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_altitude <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chk.take_sample(val);
        sent++;
    endtask

    // Drop valid and wait for every outstanding result, plus a short margin
    task automatic drain();
        i_in_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        chk.note_config(idx, data);
    endtask

    // Write either or both registers; only called with the block drained
    task automatic configure(input bit set_len, input t_cfg_data len_val,
                             input bit set_thr, input t_cfg_data thr_val);
        if (set_len) write_reg(CFG_WINDOW_LENGTH, len_val);
        if (set_thr) write_reg(CFG_DECREASE_THRESHOLD, thr_val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_phase_kind kind, input int n);
        longint                     cur;
        int                         fall_left;
        int                         r;
        bit [31:0]                  raw;
        logic signed [SAMPLE_W-1:0] pin;
        cur       = longint'($urandom_range(0, 2000000));
        fall_left = 0;
        pin       = ($urandom_range(0, 1) != 0) ? ALT_MAX[SAMPLE_W-1:0] : ALT_MIN[SAMPLE_W-1:0];
        for (int i = 0; i < n; i++) begin
            case (kind)
                PH_FLIGHT: begin
                    // climb with short falling runs, level spells and touchdowns
                    r = $urandom_range(0, 99);
                    if (fall_left > 0) begin
                        cur = cur - longint'($urandom_range(1, 3000));
                        fall_left--;
                    end else if (r < 55) begin
                        cur = cur + longint'($urandom_range(1, 5000));
                    end else if (r < 80) begin
                        fall_left = $urandom_range(1, 12);
                        cur = cur - longint'($urandom_range(1, 3000));
                    end else if (r < 92) begin
                        cur = cur;
                    end else begin
                        cur = longint'($urandom_range(0, 40)) - 20;
                    end
                    cur = to_sample(cur);
                    send_sample(to_sample(cur));
                end
                PH_GROUND: begin
                    // around zero, where the non-negative test flips
                    send_sample(to_sample(longint'($urandom_range(0, 8)) - 4));
                end
                PH_NOISE: begin
                    raw = $urandom;
                    send_sample(raw[SAMPLE_W-1:0]);
                end
                PH_EXTREME: begin
                    case ($urandom_range(0, 5))
                        0: send_sample(ALT_MAX[SAMPLE_W-1:0]);
                        1: send_sample(ALT_MIN[SAMPLE_W-1:0]);
                        2: send_sample('0);
                        3: send_sample('1);
                        4: send_sample(to_sample(1));
                        default: send_sample(to_sample(ALT_MAX - 1));
                    endcase
                end
                default: begin
                    // one extreme value over a full window: the sum at its limits
                    send_sample(pin);
                end
            endcase
        end
    endtask

    initial begin
        t_cfg_data   len_val;
        t_cfg_data   thr_val;
        bit          set_len;
        bit          set_thr;
        t_phase_kind kind;
        int          n;
        int          phase_no;
        int          steps;
        longint      cur;

        chk = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes at the reset settings
        send_sample(ALT_MAX[SAMPLE_W-1:0]);
        send_sample(ALT_MIN[SAMPLE_W-1:0]);
        send_sample('0);
        send_sample('1);
        send_sample(to_sample(1));
        // falling run one short of the threshold, then a level sample clears it
        send_sample(to_sample(1000));
        send_sample(to_sample(900));
        send_sample(to_sample(800));
        send_sample(to_sample(700));
        send_sample(to_sample(600));
        send_sample(to_sample(600));
        send_sample(to_sample(500));
        // falls below a negative sample never count
        send_sample(to_sample(-5));
        send_sample(to_sample(-10));
        drain();

        // zero length behaves as a window of one
        configure(1'b1, 8'd0, 1'b0, '0);
        send_sample(to_sample(7));
        send_sample(to_sample(-7));
        send_sample(ALT_MAX[SAMPLE_W-1:0]);
        drain();

        // lengths above the depth behave as the full depth
        configure(1'b1, 8'd127, 1'b0, '0);
        send_sample(to_sample(100));
        send_sample(to_sample(200));
        send_sample(to_sample(300));
        drain();

        // short window: wrap the ring
        configure(1'b1, 8'd3, 1'b0, '0);
        send_sample(to_sample(1));
        send_sample(to_sample(2));
        send_sample(to_sample(3));
        send_sample(to_sample(4));
        send_sample(to_sample(5));
        drain();

        // Random phases, each after writing either, both or neither register
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            set_len = ($urandom_range(0, 3) != 1);
            set_thr = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: len_val = 8'd0;
                1: len_val = 8'd1;
                2: len_val = 8'd64;
                3: len_val = t_cfg_data'($urandom_range(65, 127));
                4: len_val = 8'h80 | t_cfg_data'($urandom_range(0, 127));
                5: len_val = t_cfg_data'($urandom_range(1, 8));
                default: len_val = t_cfg_data'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 5))
                0: thr_val = 8'd1;
                1: thr_val = 8'd255;
                2: thr_val = t_cfg_data'($urandom_range(128, 254));
                3: thr_val = t_cfg_data'($urandom_range(2, 8));
                default: thr_val = t_cfg_data'($urandom_range(2, 127));
            endcase
            case ($urandom_range(0, 9))
                0: kind = PH_GROUND;
                1: kind = PH_NOISE;
                2: kind = PH_EXTREME;
                3: kind = PH_SATURATE;
                default: kind = PH_FLIGHT;
            endcase
            n = $urandom_range(5, 100);
            if (kind == PH_SATURATE) begin
                set_len = 1'b1;
                len_val = 8'd64;
                n = $urandom_range(64, 90);
            end
            calm = ($urandom_range(0, 4) == 0);
            if (phase_no == 3) begin
                // flat-out sender against a long receiver hold-off
                calm     = 1'b1;
                hold_req <= 1'b1;
                kind     = PH_FLIGHT;
                n        = 150;
            end
            configure(set_len, len_val, set_thr, thr_val);
            run_phase(kind, n);
            drain();
            phase_no++;
        end

        // Closing flight: climb, then fall steadily until apogee is declared
        calm = 1'b0;
        allow_apogee = 1'b1;
        len_val = t_cfg_data'($urandom_range(1, 64));
        thr_val = t_cfg_data'($urandom_range(2, 12));
        configure(1'b1, len_val, 1'b1, thr_val);
        cur = longint'($urandom_range(100000, 1000000));
        for (int i = 0; i < 30; i++) begin
            cur = cur + longint'($urandom_range(1, 8000));
            send_sample(to_sample(cur));
        end
        steps = 0;
        while (!chk.flag && steps < 300) begin
            cur = cur - longint'($urandom_range(1, 2000));
            send_sample(to_sample(cur));
            steps++;
        end
        // after apogee only the window moves
        run_phase(PH_FLIGHT, 40);
        drain();
        configure(1'b1, 8'd5, 1'b1, 8'd0);
        run_phase(PH_NOISE, 30);
        drain();
        repeat (10) @(posedge i_clk);

        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("tb_apogee_detect_with_moving_window_unit: clean");
        end else begin
            $display("tb_apogee_detect_with_moving_window_unit: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/adwm_pkg.sv
rtl/core/apogee_detect_with_moving_window_unit.sv
verif/tb_apogee_detect_with_moving_window_unit.sv
